>>> hdl/mse_pkg.sv
`default_nettype none

package mse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int MEM_DEPTH    = 2 ** (ADDR_W + 1);
    localparam int DATA_W       = 32;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;
    localparam int QC_W         = Q_AW + 1;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_STORE_SORT,
        CMD_SORT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [DATA_W-1:0]   value;
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    n;
        logic                ovf;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   sorted_value;
        logic                last_out;
        logic                overflow;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN_INIT,
        B_READ,
        B_CMP,
        B_EMIT_RD,
        B_EMIT_WR
    } bstate_t;

endpackage

`default_nettype wire

>>> hdl/mse_front.sv
`default_nettype none

module mse_front
    import mse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] value,
    input  wire logic               last_in,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  wire logic               cmd_pop
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    cmd_t             q_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]  fill_reg, fill_next;
    logic             accept, fits, enq;
    cmd_t             enq_cmd;

    assign full      = (fill_reg == QC_W'(Q_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign fits      = (count_reg < CNT_W'(MAX_ELEMENTS));

    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        enq           = 1'b0;
        enq_cmd.op    = CMD_STORE;
        enq_cmd.value = value;
        enq_cmd.addr  = count_reg[ADDR_W-1:0];
        enq_cmd.n     = fits ? count_reg + CNT_W'(1) : count_reg;
        enq_cmd.ovf   = ovf_reg || !fits;
        if (accept)
        begin
            if (last_in)
            begin
                enq        = 1'b1;
                enq_cmd.op = fits ? CMD_STORE_SORT : CMD_SORT;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (fits)
            begin
                enq        = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                // drop the element, remember it for the set
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (enq && !(cmd_pop && cmd_valid))
            fill_next = fill_reg + QC_W'(1);
        else if (!enq && cmd_pop && cmd_valid)
            fill_next = fill_reg - QC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            fill_reg  <= fill_next;
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (cmd_pop && cmd_valid)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            q_reg[wr_ptr_reg] <= enq_cmd;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_in |=> count_reg == '0 && !ovf_reg)
        else $error("set state not cleared after last element");

endmodule

`default_nettype wire

>>> hdl/mse_back.sv
`default_nettype none

module mse_back
    import mse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    input  wire logic res_full,
    output logic      res_push,
    output result_t   res
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic [ADDR_W:0]   rd_a_addr, rd_b_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;

    bstate_t          state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_reg, src_next;

    logic [CNT_W+1:0] mid_sum, hi_sum;
    logic [CNT_W:0]   width2;
    logic [CNT_W-1:0] k_inc;
    logic             take_left;

    assign rd_a_addr = {src_reg, i_reg[ADDR_W-1:0]};
    assign rd_b_addr = {src_reg, j_reg[ADDR_W-1:0]};
    assign mid_sum   = {2'b00, lo_reg} + {2'b00, width_reg};
    assign hi_sum    = {2'b00, lo_reg} + {1'b0, width_reg, 1'b0};
    assign width2    = {width_reg, 1'b0};
    assign k_inc     = k_reg + CNT_W'(1);
    assign take_left = (i_reg < mid_reg)
                       && ((j_reg >= hi_reg) || ($signed(rd_a_reg) <= $signed(rd_b_reg)));

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = {1'b0, cmd.addr};
        wr_data    = cmd.value;
        res_push   = 1'b0;
        res.sorted_value = rd_a_reg;
        res.last_out     = (i_reg + CNT_W'(1) == n_reg);
        res.overflow     = ovf_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    wr_en   = cmd.op inside {CMD_STORE, CMD_STORE_SORT};
                    if (cmd.op inside {CMD_STORE_SORT, CMD_SORT})
                    begin
                        n_next     = cmd.n;
                        ovf_next   = cmd.ovf;
                        width_next = CNT_W'(1);
                        lo_next    = '0;
                        i_next     = '0;
                        src_next   = 1'b0;
                        state_next = (cmd.n > CNT_W'(1)) ? B_RUN_INIT : B_EMIT_RD;
                    end
                end
            end

            B_RUN_INIT:
            begin
                // clamp both run ends to the set size
                mid_next   = (mid_sum > {2'b00, n_reg}) ? n_reg : mid_sum[CNT_W-1:0];
                hi_next    = (hi_sum > {2'b00, n_reg}) ? n_reg : hi_sum[CNT_W-1:0];
                i_next     = lo_reg;
                j_next     = mid_next;
                k_next     = lo_reg;
                state_next = B_READ;
            end

            B_READ:
            begin
                state_next = B_CMP;
            end

            B_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = {~src_reg, k_reg[ADDR_W-1:0]};
                wr_data = take_left ? rd_a_reg : rd_b_reg;
                if (take_left)
                    i_next = i_reg + CNT_W'(1);
                else
                    j_next = j_reg + CNT_W'(1);
                k_next = k_inc;
                if (k_inc != hi_reg)
                    state_next = B_READ;
                else if (hi_reg != n_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = B_RUN_INIT;
                end
                else
                begin
                    // pass done: swap buffers, double the run width or go to emit
                    src_next = ~src_reg;
                    lo_next  = '0;
                    if (width2 < {1'b0, n_reg})
                    begin
                        width_next = width2[CNT_W-1:0];
                        state_next = B_RUN_INIT;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = B_EMIT_RD;
                    end
                end
            end

            B_EMIT_RD:
            begin
                if (!res_full)
                    state_next = B_EMIT_WR;
            end

            B_EMIT_WR:
            begin
                res_push = 1'b1;
                i_next   = i_reg + CNT_W'(1);
                if (res.last_out)
                    state_next = B_IDLE;
                else
                    state_next = B_EMIT_RD;
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        ovf_reg   <= ovf_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        src_reg   <= src_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    a_cmp_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CMP |-> k_reg < hi_reg && k_reg >= lo_reg)
        else $error("merge output index outside its run");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

endmodule

`default_nettype wire

>>> hdl/mse_outq.sv
`default_nettype none

module mse_outq
    import mse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_push,
    input  result_t   res,
    output logic      res_full,
    output logic      empty,
    input  wire logic pop,
    output result_t   head
);

    result_t         q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] fill_reg, fill_next;
    logic            do_pop;

    assign res_full = (fill_reg == QC_W'(Q_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head     = q_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        fill_next = fill_reg;
        if (res_push && !do_pop)
            fill_next = fill_reg + QC_W'(1);
        else if (!res_push && do_pop)
            fill_next = fill_reg - QC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (res_push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            q_reg[wr_ptr_reg] <= res;
    end

endmodule

`default_nettype wire

>>> hdl/merge_sort_engine.sv
// Load: one element per cycle while not full, via a 4-entry command queue to the buffer.
// Sort: ceil(log2 n) merge passes; each run starts with a run-init state and each element
//   moves through a read state and a compare/write state on the single buffer memory.
// Emit: each result passes a read state and a push state into a 4-entry result queue,
//   waiting in the read state while that queue is full.
// Reset clears front and queue counters, pointers and sequencer; buffers are not cleared.
`default_nettype none

module merge_sort_engine
    import mse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] value,
    input  wire logic               last_in,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      sorted_value,
    output logic                    last_out,
    output logic                    overflow
);

    cmd_t    cmd;
    logic    cmd_valid, cmd_pop;
    result_t res, head;
    logic    res_push, res_full;

    mse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .last_in   (last_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    mse_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign sorted_value = $signed(head.sorted_value);
    assign last_out     = head.last_out;
    assign overflow     = head.overflow;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mse_pkg::*;

    localparam int TOTAL_ITEMS    = 480;
    localparam int CALM_ITEMS     = 80;
    localparam int RX_HOLD_CYCLES = 1500;
    localparam int TAIL_CYCLES    = 300;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        VALS_WIDE,
        VALS_NARROW,
        VALS_EDGES
    } val_flavor_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic               l;
        logic               typed;
        logic signed [31:0] ev;
        logic               el;
        logic               eo;
    } stim_row_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic signed [31:0] value   = '0;
    logic               last_in = 1'b0;
    logic               pop     = 1'b0;
    wire                full;
    wire                empty;
    wire signed [31:0]  sorted_value;
    wire                last_out;
    wire                overflow;

    // predictor state
    logic signed [31:0] held_vals [MAX_ELEMENTS];
    int unsigned        held_cnt = 0;
    logic               held_ovf = 1'b0;
    result_t            sorted_run [$];
    result_t            pending_results [$];

    int                 mismatch_count = 0;
    int                 sent_count     = 0;
    bit                 rx_hold_req    = 1'b0;
    int                 stall_left     = 0;
    stim_row_t          directed_rows [19];

    merge_sort_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .value        (value),
        .last_in      (last_in),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit calm_phase();
        return sent_count >= TOTAL_ITEMS - CALM_ITEMS;
    endfunction

    // Store one element; on the closing element sort the set into sorted_run.
    function automatic void absorb_element(logic signed [31:0] v, logic l);
        logic signed [31:0] src [MAX_ELEMENTS];
        logic signed [31:0] dst [MAX_ELEMENTS];
        int                 n;
        int                 w;
        int                 lo;
        int                 mid;
        int                 hi;
        int                 i;
        int                 j;
        int                 k;
        result_t            r;
        if (held_cnt < MAX_ELEMENTS)
        begin
            held_vals[held_cnt] = v;
            held_cnt++;
        end
        else
            held_ovf = 1'b1;
        if (!l)
            return;
        n   = held_cnt;
        src = held_vals;
        dst = held_vals;
        for (w = 1; w < n; w = w * 2)
        begin
            for (lo = 0; lo < n; lo = lo + 2 * w)
            begin
                mid = (lo + w < n) ? lo + w : n;
                hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
                i   = lo;
                j   = mid;
                // left run wins on ties
                for (k = lo; k < hi; k++)
                begin
                    if (j >= hi || (i < mid && src[i] <= src[j]))
                    begin
                        dst[k] = src[i];
                        i++;
                    end
                    else
                    begin
                        dst[k] = src[j];
                        j++;
                    end
                end
            end
            src = dst;
        end
        for (k = 0; k < n; k++)
        begin
            r.sorted_value = src[k];
            r.last_out     = (k == n - 1);
            r.overflow     = held_ovf;
            sorted_run.push_back(r);
        end
        held_cnt = 0;
        held_ovf = 1'b0;
    endfunction

    function automatic logic signed [31:0] random_value(val_flavor_t flavor);
        logic signed [31:0] v;
        case (flavor)
            VALS_NARROW: v = $signed($urandom_range(0, 8)) - 4;
            VALS_EDGES:
            begin
                case ($urandom_range(0, 5))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    3: v = -1;
                    4: v = VAL_MIN + 1;
                    default: v = VAL_MAX - 1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_row(stim_row_t row);
        result_t fixed;
        if (!calm_phase() && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        push    <= 1'b1;
        value   <= row.v;
        last_in <= row.l;
        do
            @(posedge clk);
        while (full);
        absorb_element(row.v, row.l);
        if (row.typed)
        begin
            fixed.sorted_value = row.ev;
            fixed.last_out     = row.el;
            fixed.overflow     = row.eo;
            pending_results.push_back(fixed);
        end
        else
        begin
            foreach (sorted_run[k])
                pending_results.push_back(sorted_run[k]);
        end
        sorted_run.delete();
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_set(int n, val_flavor_t flavor);
        stim_row_t row;
        for (int k = 0; k < n; k++)
        begin
            row       = '0;
            row.v     = random_value(flavor);
            row.l     = (k == n - 1);
            send_row(row);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // receiver: random pop bursts, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (!calm_phase() && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: sorted_value %0d", sorted_value);
                mismatch_count++;
            end
            else
            begin
                if (sorted_value !== $signed(pending_results[0].sorted_value))
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           $signed(pending_results[0].sorted_value), sorted_value);
                    mismatch_count++;
                end
                if (last_out !== pending_results[0].last_out)
                begin
                    $error("last_out: expected %0b, actual %0b",
                           pending_results[0].last_out, last_out);
                    mismatch_count++;
                end
                if (overflow !== pending_results[0].overflow)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           pending_results[0].overflow, overflow);
                    mismatch_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial
    begin
        int          n;
        int          pick;
        bit          mid_pause_done;
        val_flavor_t flavor;

        mid_pause_done = 1'b0;
        directed_rows = '{
            // single-element sets: the element comes straight back
            '{VAL_MIN,       1'b1, 1'b1, VAL_MIN,       1'b1, 1'b0},
            '{VAL_MAX,       1'b1, 1'b1, VAL_MAX,       1'b1, 1'b0},
            '{32'sd0,        1'b1, 1'b1, 32'sd0,        1'b1, 1'b0},
            '{-32'sd1,       1'b1, 1'b1, -32'sd1,       1'b1, 1'b0},
            '{32'sh5555_5555, 1'b1, 1'b1, 32'sh5555_5555, 1'b1, 1'b0},
            '{32'shAAAA_AAAA, 1'b1, 1'b1, 32'shAAAA_AAAA, 1'b1, 1'b0},
            // mixed signs, duplicates and both extremes
            '{32'sd7,        1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{-32'sd7,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{32'sd7,        1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{VAL_MAX,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{VAL_MIN,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{32'sd0,        1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{-32'sd1,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{32'sd7,        1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
            // reversed pair
            '{32'sd100,      1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{-32'sd100,     1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
            // all equal
            '{32'sd42,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{32'sd42,       1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
            '{32'sd42,       1'b1, 1'b0, 32'sd0, 1'b0, 1'b0}
        };

        @(posedge rst_n);
        @(negedge clk);
        foreach (directed_rows[r])
            send_row(directed_rows[r]);

        // hold the receiver while a full set and an overflowing set go in
        rx_hold_req = 1'b1;
        send_set(MAX_ELEMENTS, VALS_WIDE);
        send_set(MAX_ELEMENTS + 6, VALS_NARROW);
        wait_drained();
        @(negedge clk);

        while (sent_count < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (calm_phase())
                n = $urandom_range(1, 12);
            else if (pick < 55)
                n = $urandom_range(1, 8);
            else if (pick < 80)
                n = $urandom_range(9, 24);
            else if (pick < 92)
                n = $urandom_range(25, MAX_ELEMENTS - 1);
            else if (pick < 96)
                n = MAX_ELEMENTS;
            else
                n = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 8);
            pick = $urandom_range(0, 9);
            flavor = (pick < 6) ? VALS_WIDE : (pick < 8) ? VALS_NARROW : VALS_EDGES;
            send_set(n, flavor);
            if (!mid_pause_done && sent_count >= TOTAL_ITEMS / 2)
            begin
                mid_pause_done = 1'b1;
                wait_drained();
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> merge_sort_engine.f
hdl/mse_pkg.sv
hdl/mse_front.sv
hdl/mse_back.sv
hdl/mse_outq.sv
hdl/merge_sort_engine.sv
tb/tb_top.sv
